>>> rtl/rsi_pkg.sv
// Shared constants for the ray/sphere intersection block.
// Port widths, fixed-point defaults and configuration register indexes.
// No dependencies.
package rsi_pkg;

  localparam int COORD_W       = 32;  // signed coordinates and directions
  localparam int RAD_W         = 31;  // unsigned sphere radius
  localparam int HIT_T_W       = 31;  // unsigned ray parameter of the hit
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Width of the sums of products before the fraction is dropped.
  localparam int SUM_W = 70;
  // Quotient magnitude bits kept by the dividers; larger values saturate.
  localparam int QUO_W = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;

endpackage

>>> rtl/ray_sphere_intersect_top.sv
// Ray/sphere intersection, fully pipelined, one ray per cycle.
// Depends on rsi_pkg, rsi_delay, rsi_smul, rsi_sqrt_cell and rsi_div_cell.
//
// Usage:
//   Input: drive the ray on in_origin_* / in_dir_* (signed fixed point) and
//   raise start; the item is taken at any edge with start high and busy low.
//   busy stays low, so a new ray can enter in every cycle.
//   Output: out_valid strobes for exactly one cycle with out_hit, out_hit_t
//   and out_point_*; the receiver cannot stall, so take the item then.
//   A miss gives zero on every result field.
//   The pipeline holds the square root chain (one root bit per cell) and
//   then the two divider chains (one quotient bit per cell) side by side.
//   Throughput: one item per cycle.
//   Configuration: cfg_ready is always high; write center and radius through
//   cfg_index / cfg_data only while no item is in flight.
//   Reset (rst_n low, synchronous): drop all items in flight, center to zero,
//   radius to 1 << 16 (1.0 at FRAC_BITS = 16).
module ray_sphere_intersect_top #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rsi_pkg::COORD_W-1:0]   in_origin_x,
  input  logic signed [rsi_pkg::COORD_W-1:0]   in_origin_y,
  input  logic signed [rsi_pkg::COORD_W-1:0]   in_origin_z,
  input  logic signed [rsi_pkg::COORD_W-1:0]   in_dir_x,
  input  logic signed [rsi_pkg::COORD_W-1:0]   in_dir_y,
  input  logic signed [rsi_pkg::COORD_W-1:0]   in_dir_z,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [rsi_pkg::HIT_T_W-1:0]          out_hit_t,
  output logic signed [rsi_pkg::COORD_W-1:0]   out_point_x,
  output logic signed [rsi_pkg::COORD_W-1:0]   out_point_y,
  output logic signed [rsi_pkg::COORD_W-1:0]   out_point_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import rsi_pkg::*;

  // Widths that follow from the fraction size.
  localparam int AHW = SUM_W - FRAC_BITS;   // a, h, c and the root
  localparam int DW2 = 2 * AHW;              // radicand
  localparam int QW  = AHW + 2;              // q and divisor magnitudes
  localparam int NW  = QW + FRAC_BITS;       // scaled numerators
  localparam int PMW = COORD_W + 64;         // d * t product
  localparam int PSW = PMW + 1;              // point sum before saturation
  localparam int LAT = 13 + AHW + QUO_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [RAD_W-1:0]          sphere_radius_r;
  logic                      cfg_we;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r      <= '0;
      center_y_r      <= '0;
      center_z_r      <= '0;
      sphere_radius_r <= RAD_W'(1 << 16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x_r      <= $signed(cfg_data);
        CFG_CENTER_Y: center_y_r      <= $signed(cfg_data);
        CFG_CENTER_Z: center_z_r      <= $signed(cfg_data);
        CFG_RADIUS:   sphere_radius_r <= cfg_data[RAD_W-1:0];
        default: ;    // unknown index: ignore
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Valid tracking: one bit per pipeline stage
  // ---------------------------------------------------------------------------
  logic           in_acc;
  logic [LAT-1:0] vld_r;

  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_acc};
    end
  end

  assign out_valid = vld_r[LAT-1];

  // ---------------------------------------------------------------------------
  // Capture: move the origin into sphere space
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] o0_r [3];
  logic signed [COORD_W-1:0] d0_r [3];
  logic signed [COORD_W:0]   p0_r [3];
  logic signed [COORD_W:0]   rad0_r;

  always_ff @(posedge clk) begin
    o0_r[0] <= in_origin_x;
    o0_r[1] <= in_origin_y;
    o0_r[2] <= in_origin_z;
    d0_r[0] <= in_dir_x;
    d0_r[1] <= in_dir_y;
    d0_r[2] <= in_dir_z;
    p0_r[0] <= (COORD_W+1)'(in_origin_x) - (COORD_W+1)'(center_x_r);
    p0_r[1] <= (COORD_W+1)'(in_origin_y) - (COORD_W+1)'(center_y_r);
    p0_r[2] <= (COORD_W+1)'(in_origin_z) - (COORD_W+1)'(center_z_r);
    rad0_r  <= $signed({2'b00, sphere_radius_r});
  end

  // ---------------------------------------------------------------------------
  // Products for a, h, c
  // ---------------------------------------------------------------------------
  localparam int M1W = 2 * (COORD_W + 1);

  logic signed [M1W-1:0] dd [3];
  logic signed [M1W-1:0] dp [3];
  logic signed [M1W-1:0] pp [3];
  logic signed [M1W-1:0] rr;

  for (genvar i = 0; i < 3; i++) begin : g_m1
    rsi_smul #(.WA(COORD_W+1), .WB(COORD_W+1)) u_dd (
      .clk(clk), .a((COORD_W+1)'(d0_r[i])), .b((COORD_W+1)'(d0_r[i])), .p(dd[i]));
    rsi_smul #(.WA(COORD_W+1), .WB(COORD_W+1)) u_dp (
      .clk(clk), .a((COORD_W+1)'(d0_r[i])), .b(p0_r[i]), .p(dp[i]));
    rsi_smul #(.WA(COORD_W+1), .WB(COORD_W+1)) u_pp (
      .clk(clk), .a(p0_r[i]), .b(p0_r[i]), .p(pp[i]));
  end

  rsi_smul #(.WA(COORD_W+1), .WB(COORD_W+1)) u_rr (
    .clk(clk), .a(rad0_r), .b(rad0_r), .p(rr));

  // Sum and drop the fraction: a, h, c in fixed point.
  logic signed [SUM_W-1:0] sa, sh, sc;
  logic signed [AHW-1:0]   a1_r, h1_r, c1_r;

  assign sa = SUM_W'(dd[0]) + SUM_W'(dd[1]) + SUM_W'(dd[2]);
  assign sh = SUM_W'(dp[0]) + SUM_W'(dp[1]) + SUM_W'(dp[2]);
  assign sc = SUM_W'(pp[0]) + SUM_W'(pp[1]) + SUM_W'(pp[2]) - SUM_W'(rr);

  always_ff @(posedge clk) begin
    a1_r <= AHW'(sa >>> FRAC_BITS);
    h1_r <= AHW'(sh >>> FRAC_BITS);
    c1_r <= AHW'(sc >>> FRAC_BITS);
  end

  // ---------------------------------------------------------------------------
  // Discriminant h^2 - a*c
  // ---------------------------------------------------------------------------
  logic signed [DW2-1:0] hh, ac;
  logic signed [DW2:0]   disc;
  logic [DW2-1:0]        disc_r;
  logic                  dneg_r;

  rsi_smul #(.WA(AHW), .WB(AHW)) u_hh (.clk(clk), .a(h1_r), .b(h1_r), .p(hh));
  rsi_smul #(.WA(AHW), .WB(AHW)) u_ac (.clk(clk), .a(a1_r), .b(c1_r), .p(ac));

  assign disc = (DW2+1)'(hh) - (DW2+1)'(ac);

  // A negative discriminant is a miss; feed zero to the root chain.
  always_ff @(posedge clk) begin
    dneg_r <= disc[DW2];
    disc_r <= disc[DW2] ? '0 : disc[DW2-1:0];
  end

  // ---------------------------------------------------------------------------
  // Square root chain: one root bit per cell
  // ---------------------------------------------------------------------------
  logic [DW2-1:0] sq_rad  [AHW+1];
  logic [AHW:0]   sq_rem  [AHW+1];
  logic [AHW-1:0] sq_root [AHW+1];

  assign sq_rad[0]  = disc_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < AHW; k++) begin : g_sqrt
    rsi_sqrt_cell #(.RW(AHW)) u_cell (
      .clk(clk),
      .rad_i(sq_rad[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]),
      .rad_o(sq_rad[k+1]), .rem_o(sq_rem[k+1]), .root_o(sq_root[k+1]));
  end

  // Hold a, h, c and the discriminant sign alongside the root chain.
  logic [3*AHW-1:0]      ahc_d;
  logic signed [AHW-1:0] a2, h2, c2;
  logic                  dneg2;

  rsi_delay #(.W(3*AHW), .N(3 + AHW)) u_ahc_dly (
    .clk(clk), .d({a1_r, h1_r, c1_r}), .q(ahc_d));
  rsi_delay #(.W(1), .N(AHW)) u_dneg_dly (.clk(clk), .d(dneg_r), .q(dneg2));

  assign a2 = $signed(ahc_d[3*AHW-1 -: AHW]);
  assign h2 = $signed(ahc_d[2*AHW-1 -: AHW]);
  assign c2 = $signed(ahc_d[AHW-1:0]);

  // ---------------------------------------------------------------------------
  // Stable q form: q = -(h + sign(h) * sqrt(disc))
  // ---------------------------------------------------------------------------
  logic signed [QW-1:0]  s_ext, h_ext, q_val;
  logic signed [QW-1:0]  q3_r;
  logic signed [AHW-1:0] a3_r, c3_r;
  logic                  miss3_r;

  assign s_ext = QW'($signed({1'b0, sq_root[AHW]}));
  assign h_ext = QW'(h2);
  assign q_val = h2[AHW-1] ? (s_ext - h_ext) : (-h_ext - s_ext);

  always_ff @(posedge clk) begin
    q3_r    <= q_val;
    a3_r    <= a2;
    c3_r    <= c2;
    miss3_r <= dneg2 || (a2 == '0) || (q_val == '0);
  end

  // ---------------------------------------------------------------------------
  // Divider set-up: t0 = q / a, t1 = c / q on magnitudes
  // ---------------------------------------------------------------------------
  localparam int NHI = NW - QUO_W;

  logic [QW-1:0]    qm, cm, am;
  logic [NW-1:0]    n0, n1;
  logic [QW-1:0]    hi0, hi1;
  logic             ovf0, ovf1;
  logic [QUO_W-1:0] num4_r [2];
  logic [QW-1:0]    rem4_r [2];
  logic [QW-1:0]    dv4_r  [2];
  logic [4:0]       flg4_r;   // {miss, neg1, neg0, ovf1, ovf0}

  assign qm  = q3_r[QW-1] ? $unsigned(-q3_r) : $unsigned(q3_r);
  assign cm  = QW'(c3_r[AHW-1] ? $unsigned(-c3_r) : $unsigned(c3_r));
  assign am  = QW'($unsigned(a3_r));
  assign n0  = NW'(qm) << FRAC_BITS;
  assign n1  = NW'(cm) << FRAC_BITS;
  assign hi0 = QW'(n0[NW-1 -: NHI]);
  assign hi1 = QW'(n1[NW-1 -: NHI]);
  // Quotient of more than QUO_W bits: saturate it.
  assign ovf0 = (hi0 >= am);
  assign ovf1 = (hi1 >= qm);

  always_ff @(posedge clk) begin
    num4_r[0] <= n0[QUO_W-1:0];
    num4_r[1] <= n1[QUO_W-1:0];
    rem4_r[0] <= ovf0 ? '0 : hi0;
    rem4_r[1] <= ovf1 ? '0 : hi1;
    dv4_r[0]  <= am;
    dv4_r[1]  <= qm;
    flg4_r    <= {miss3_r, c3_r[AHW-1] ^ q3_r[QW-1], q3_r[QW-1], ovf1, ovf0};
  end

  // ---------------------------------------------------------------------------
  // Divider chains: two lanes, one quotient bit per cell
  // ---------------------------------------------------------------------------
  logic [QUO_W-1:0] dv_num [2][QUO_W+1];
  logic [QW-1:0]    dv_rem [2][QUO_W+1];
  logic [QW-1:0]    dv_dv  [2][QUO_W+1];
  logic [QUO_W-1:0] dv_q   [2][QUO_W+1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign dv_num[l][0] = num4_r[l];
    assign dv_rem[l][0] = rem4_r[l];
    assign dv_dv[l][0]  = dv4_r[l];
    assign dv_q[l][0]   = '0;
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
      rsi_div_cell #(.DW(QW), .QB(QUO_W)) u_cell (
        .clk(clk),
        .num_i(dv_num[l][k]), .rem_i(dv_rem[l][k]),
        .dv_i(dv_dv[l][k]), .q_i(dv_q[l][k]),
        .num_o(dv_num[l][k+1]), .rem_o(dv_rem[l][k+1]),
        .dv_o(dv_dv[l][k+1]), .q_o(dv_q[l][k+1]));
    end
  end

  logic [4:0] flg5;

  rsi_delay #(.W(5), .N(QUO_W)) u_flg_dly (.clk(clk), .d(flg4_r), .q(flg5));

  // ---------------------------------------------------------------------------
  // Root selection: nearest non-negative t
  // ---------------------------------------------------------------------------
  logic [QUO_W-1:0]  mag0, mag1;
  logic signed [63:0] t0s, t1s, lo, hi;
  logic [QUO_W-1:0]  t_sel;
  logic [QUO_W-1:0]  tc_r;
  logic [HIT_T_W-1:0] hitt_r;
  logic              hit_r;

  assign mag0 = flg5[0] ? '1 : dv_q[0][QUO_W];
  assign mag1 = flg5[1] ? '1 : dv_q[1][QUO_W];
  assign t0s  = flg5[2] ? -$signed(64'(mag0)) : $signed(64'(mag0));
  assign t1s  = flg5[3] ? -$signed(64'(mag1)) : $signed(64'(mag1));
  assign lo   = (t1s < t0s) ? t1s : t0s;
  assign hi   = (t1s < t0s) ? t0s : t1s;
  assign t_sel = lo[63] ? hi[QUO_W-1:0] : lo[QUO_W-1:0];

  // Clamp t to 2^62 for the point product and to the port range for hit_t.
  always_ff @(posedge clk) begin
    hit_r  <= !flg5[4] && !hi[63];
    tc_r   <= (t_sel[QUO_W-1] && (|t_sel[QUO_W-2:0])) ? {1'b1, {(QUO_W-1){1'b0}}} : t_sel;
    hitt_r <= (|t_sel[QUO_W-1:HIT_T_W]) ? '1 : t_sel[HIT_T_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Hit point: origin + d * t
  // ---------------------------------------------------------------------------
  logic [6*COORD_W-1:0]      od_d;
  logic signed [COORD_W-1:0] d5 [3];
  logic [3*COORD_W-1:0]      o_d;
  logic signed [PMW-1:0]     dt [3];
  logic signed [COORD_W-1:0] pt_sat [3];
  logic                      hit6;
  logic [HIT_T_W-1:0]        hitt6;

  rsi_delay #(.W(6*COORD_W), .N(9 + AHW + QUO_W)) u_od_dly (
    .clk(clk),
    .d({o0_r[0], o0_r[1], o0_r[2], d0_r[0], d0_r[1], d0_r[2]}),
    .q(od_d));
  rsi_delay #(.W(3*COORD_W), .N(2)) u_o_dly (
    .clk(clk), .d(od_d[6*COORD_W-1 -: 3*COORD_W]), .q(o_d));
  rsi_delay #(.W(1 + HIT_T_W), .N(2)) u_hit_dly (
    .clk(clk), .d({hit_r, hitt_r}), .q({hit6, hitt6}));

  for (genvar i = 0; i < 3; i++) begin : g_pt
    logic signed [COORD_W-1:0] o6;
    logic signed [PMW-1:0]     m;
    logic signed [PSW-1:0]     ps;
    logic                      in_rng;

    assign d5[i] = $signed(od_d[(3-i)*COORD_W-1 -: COORD_W]);
    assign o6    = $signed(o_d[(3-i)*COORD_W-1 -: COORD_W]);

    rsi_smul #(.WA(COORD_W), .WB(64)) u_dt (
      .clk(clk), .a(d5[i]), .b($signed({1'b0, tc_r})), .p(dt[i]));

    assign m      = dt[i] >>> FRAC_BITS;
    assign ps     = PSW'(m) + PSW'(o6);
    assign in_rng = (&ps[PSW-1:COORD_W-1]) || !(|ps[PSW-1:COORD_W-1]);

    // Saturate the point coordinate to the port range.
    assign pt_sat[i] = in_rng ? ps[COORD_W-1:0]
                              : {ps[PSW-1], {(COORD_W-1){!ps[PSW-1]}}};
  end

  always_ff @(posedge clk) begin
    out_hit     <= hit6;
    out_hit_t   <= hit6 ? hitt6 : '0;
    out_point_x <= hit6 ? pt_sat[0] : '0;
    out_point_y <= hit6 ? pt_sat[1] : '0;
    out_point_z <= hit6 ? pt_sat[2] : '0;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_out_follows_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LAT))
    else $error("result item without an accepted input item");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_t == '0 && out_point_x == '0 &&
                                 out_point_y == '0 && out_point_z == '0))
    else $error("miss with nonzero result fields");

  a_radius_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_RADIUS) |=> (sphere_radius_r == $past(cfg_data[RAD_W-1:0])))
    else $error("radius write lost");

endmodule

>>> rtl/rsi_delay.sv
// Fixed-length shift line that delays a word; parameter N sets its length.
// No dependencies.
module rsi_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
    for (int i = 1; i < N; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

>>> rtl/rsi_smul.sv
// Two-stage signed multiplier built from four half-width partial products.
// No dependencies.
module rsi_smul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int HA = (WA + 1) / 2;
  localparam int HB = (WB + 1) / 2;
  localparam int UA = WA - HA;
  localparam int UB = WB - HB;
  localparam int PW = WA + WB;

  logic [WA-1:0]      ma;
  logic [WB-1:0]      mb;
  logic [HA+HB-1:0]   pp00_r, pp00_nxt;
  logic [HA+UB-1:0]   pp01_r, pp01_nxt;
  logic [UA+HB-1:0]   pp10_r, pp10_nxt;
  logic [UA+UB-1:0]   pp11_r, pp11_nxt;
  logic               neg_r, neg_nxt;
  logic [PW-1:0]      sum;
  logic signed [PW-1:0] p_r, p_nxt;

  // Magnitudes; the most negative value maps onto its own unsigned magnitude.
  assign ma = a[WA-1] ? $unsigned(-a) : $unsigned(a);
  assign mb = b[WB-1] ? $unsigned(-b) : $unsigned(b);

  assign pp00_nxt = (HA+HB)'(ma[HA-1:0])  * (HA+HB)'(mb[HB-1:0]);
  assign pp01_nxt = (HA+UB)'(ma[HA-1:0])  * (HA+UB)'(mb[WB-1:HB]);
  assign pp10_nxt = (UA+HB)'(ma[WA-1:HA]) * (UA+HB)'(mb[HB-1:0]);
  assign pp11_nxt = (UA+UB)'(ma[WA-1:HA]) * (UA+UB)'(mb[WB-1:HB]);
  assign neg_nxt  = a[WA-1] ^ b[WB-1];

  assign sum   = PW'(pp00_r) + (PW'(pp01_r) << HB) + (PW'(pp10_r) << HA)
               + (PW'(pp11_r) << (HA + HB));
  assign p_nxt = neg_r ? -$signed(sum) : $signed(sum);

  always_ff @(posedge clk) begin
    pp00_r <= pp00_nxt;
    pp01_r <= pp01_nxt;
    pp10_r <= pp10_nxt;
    pp11_r <= pp11_nxt;
    neg_r  <= neg_nxt;
    p_r    <= p_nxt;
  end

  assign p = p_r;

endmodule

>>> rtl/rsi_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cycle.
// No dependencies.
module rsi_sqrt_cell #(
  parameter int RW = 54
) (
  input  logic            clk,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW:0]     rem_i,
  input  logic [RW-1:0]   root_i,
  output logic [2*RW-1:0] rad_o,
  output logic [RW:0]     rem_o,
  output logic [RW-1:0]   root_o
);

  logic [RW+2:0]   r4;
  logic [RW+2:0]   trial;
  logic            ge;
  logic [2*RW-1:0] rad_r, rad_nxt;
  logic [RW:0]     rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;

  // Bring down the next two radicand bits and try appending a one.
  assign r4       = {rem_i, rad_i[2*RW-1 -: 2]};
  assign trial    = {1'b0, root_i, 2'b01};
  assign ge       = (r4 >= trial);
  assign rem_nxt  = (RW+1)'(ge ? (r4 - trial) : r4);
  assign root_nxt = {root_i[RW-2:0], ge};
  assign rad_nxt  = {rad_i[2*RW-3:0], 2'b00};

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

>>> rtl/rsi_div_cell.sv
// One cell of a restoring divider chain: settles one quotient bit per cycle.
// No dependencies.
module rsi_div_cell #(
  parameter int DW = 56,
  parameter int QB = 63
) (
  input  logic          clk,
  input  logic [QB-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] dv_i,
  input  logic [QB-1:0] q_i,
  output logic [QB-1:0] num_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] dv_o,
  output logic [QB-1:0] q_o
);

  logic [DW:0]   r2;
  logic          ge;
  logic [QB-1:0] num_r, num_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dv_r;
  logic [QB-1:0] q_r, q_nxt;

  assign r2      = {rem_i, num_i[QB-1]};
  assign ge      = (r2 >= {1'b0, dv_i});
  assign rem_nxt = DW'(ge ? (r2 - {1'b0, dv_i}) : r2);
  assign q_nxt   = {q_i[QB-2:0], ge};
  assign num_nxt = {num_i[QB-2:0], 1'b0};

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_i;
    q_r   <= q_nxt;
  end

  assign num_o = num_r;
  assign rem_o = rem_r;
  assign dv_o  = dv_r;
  assign q_o   = q_r;

endmodule
